// ===== rtl/core/dvfc_pkg.sv =====
package dvfc_pkg;

    localparam int VAL_W         = 32;
    localparam int OCC_W         = 6;
    localparam int MAX_ITEMS_DEF = 32;

    localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};
    localparam logic [OCC_W-1:0] OCC_ONE = OCC_W'(1);

    typedef struct packed {
        logic signed [VAL_W-1:0] sample_value;
        logic                    final_item;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] distinct_value;
        logic [OCC_W-1:0]        occurrences;
        logic                    run_end;
        logic                    dropped_items;
    } t_out;

    // Per-cell control, driven by the sequencer in the top level.
    typedef struct packed {
        logic in_use;
        logic accept;
        logic append;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_DRAIN   = 2'b10
    } t_state;

endpackage

// ===== rtl/core/distinct_value_frequency_counter_top.sv =====
// Channel   Direction  Handshake                  Payload
// item      in         start high, busy low       i_item   (t_in)
// result    out        o_strobe, one cycle only   o_result (t_out)
//
// While a data set is being collected one transaction is taken in every cycle.
// A final_item transaction starts a drain that shifts the entries along the cell
// row and gives one result per distinct value held; busy stays high throughout.
// Reset is synchronous and clears the sequencer and counters only; the cells
// hold no valid bits, as the entry count says which of them are in use.
// The receiver cannot stall: each result is shown for exactly one cycle.
module distinct_value_frequency_counter_top
    import dvfc_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_result
);

    // The counters must be able to hold MAX_ITEMS itself.
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_taken, n_taken;
    logic             r_ovf, n_ovf;
    logic             r_drop, n_drop;
    logic             r_strobe;
    t_out             r_result;

    logic                    accept;
    logic                    take;
    logic                    any_match;
    logic                    append_any;
    logic                    draining;
    logic [MAX_ITEMS-1:0]    match;
    logic signed [VAL_W-1:0] cell_val [MAX_ITEMS];
    logic [OCC_W-1:0]        cell_cnt [MAX_ITEMS];
    logic signed [VAL_W-1:0] nb_val   [MAX_ITEMS];
    logic [OCC_W-1:0]        nb_cnt   [MAX_ITEMS];
    t_cell_ctrl              ctrl     [MAX_ITEMS];

    assign draining   = (r_state == ST_DRAIN);
    assign busy       = draining;
    assign accept     = start && !draining;
    // A transaction beyond capacity is not counted, but it can still end the set.
    assign take       = (r_taken < CNT_MAX);
    assign any_match  = |match;
    assign append_any = accept && take && !any_match;

    // The row of cells. Each compares the incoming sample in parallel and,
    // while draining, hands its entry one place towards cell zero.
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        if (g == MAX_ITEMS - 1) begin : g_tail
            assign nb_val[g] = '0;
            assign nb_cnt[g] = '0;
        end else begin : g_link
            assign nb_val[g] = cell_val[g+1];
            assign nb_cnt[g] = cell_cnt[g+1];
        end

        always_comb begin
            ctrl[g].in_use = (CNT_W'(g) < r_used);
            ctrl[g].accept = accept && take;
            ctrl[g].append = append_any && (CNT_W'(g) == r_used);
            ctrl[g].shift  = draining;
        end

        dvfc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl[g]),
            .i_sample   (i_item.sample_value),
            .i_nb_value (nb_val[g]),
            .i_nb_count (nb_cnt[g]),
            .o_value    (cell_val[g]),
            .o_count    (cell_cnt[g]),
            .o_match    (match[g])
        );
    end

    // Sequencer: collect transactions, then drain the row after a final one.
    always_comb begin
        n_state = r_state;
        n_used  = r_used;
        n_taken = r_taken;
        n_ovf   = r_ovf;
        n_drop  = r_drop;
        unique case (r_state)
            ST_COLLECT: begin
                if (accept) begin
                    if (take) begin
                        n_taken = r_taken + CNT_ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (append_any) begin
                        n_used = r_used + CNT_ONE;
                    end
                    if (i_item.final_item) begin
                        // The flag for the whole set is frozen here and the
                        // set counters start afresh for the next one.
                        n_drop  = r_ovf || !take;
                        n_ovf   = 1'b0;
                        n_taken = '0;
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                n_used = r_used - CNT_ONE;
                if (r_used == CNT_ONE) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_COLLECT;
            r_used   <= '0;
            r_taken  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_taken  <= n_taken;
            r_ovf    <= n_ovf;
            r_strobe <= draining;
        end
    end

    // The result register takes the head of the row on each drain cycle.
    always_ff @(posedge i_clk) begin
        r_drop <= n_drop;
        if (draining) begin
            r_result.distinct_value <= cell_val[0];
            r_result.occurrences    <= cell_cnt[0];
            r_result.run_end        <= (r_used == CNT_ONE);
            r_result.dropped_items  <= r_drop;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== rtl/core/dvfc_cell.sv =====
module dvfc_cell
    import dvfc_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctrl              i_ctrl,
    input  logic signed [VAL_W-1:0] i_sample,
    input  logic signed [VAL_W-1:0] i_nb_value,
    input  logic [OCC_W-1:0]        i_nb_count,
    output logic signed [VAL_W-1:0] o_value,
    output logic [OCC_W-1:0]        o_count,
    output logic                    o_match
);

    logic signed [VAL_W-1:0] r_value;
    logic [OCC_W-1:0]        r_count;

    assign o_match = i_ctrl.in_use && (r_value == i_sample);
    assign o_value = r_value;
    assign o_count = r_count;

    // During the drain every cell takes the contents of its right-hand neighbour.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= i_nb_value;
            r_count <= i_nb_count;
        end else if (i_ctrl.accept && o_match) begin
            if (r_count != OCC_MAX) begin
                r_count <= r_count + OCC_ONE;
            end
        end else if (i_ctrl.append) begin
            r_value <= i_sample;
            r_count <= OCC_ONE;
        end
    end

endmodule

// ===== rtl/core/dvfc_checker.sv =====
module dvfc_checker
    import dvfc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_in  i_item,
    input logic o_strobe,
    input t_out o_result
);

    // Results only come out of a drain.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a preceding drain cycle");

    // A final transaction starts a drain.
    a_final_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.final_item) |=> busy)
        else $error("final transaction did not start a drain");

    // More results of the set follow while busy stays high.
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.run_end) |-> busy)
        else $error("drain ended before the last result");

    // The last result closes the drain.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.run_end) |-> !busy)
        else $error("drain continues after the last result");

    a_fall_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_result.run_end))
        else $error("busy fell without the last result");

endmodule

bind distinct_value_frequency_counter_top dvfc_checker u_dvfc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
